/* sv/rfpr_pkg.sv */
package rfpr_pkg;

	localparam int RECORD_SLOTS     = 16;
	localparam int MAX_RECORD_BYTES = 64;
	localparam int STORE_BYTES      = RECORD_SLOTS * MAX_RECORD_BYTES;
	localparam int SLOT_W           = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
	localparam int USED_W           = $clog2(RECORD_SLOTS + 1);
	localparam int OFF_W            = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
	localparam int ADDR_W           = $clog2(STORE_BYTES);
	localparam int LEN_W            = 7;
	localparam int CMDQ_DEPTH       = 2;
	localparam int CMDQ_CNT_W       = $clog2(CMDQ_DEPTH + 1);
	localparam int CMDQ_PTR_W       = $clog2(CMDQ_DEPTH);
	localparam int RESQ_DEPTH       = 4;
	localparam int RESQ_CNT_W       = $clog2(RESQ_DEPTH + 1);
	localparam int RESQ_PTR_W       = $clog2(RESQ_DEPTH);

	typedef enum logic [1:0] {
		FN_APPEND = 2'd0,
		FN_GET    = 2'd1,
		FN_DELETE = 2'd2,
		FN_PEEK   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	typedef enum logic {
		BK_IDLE,
		BK_STREAM
	} back_state_t;

	typedef struct packed {
		func_t              func;
		logic [7:0]         data_byte;
		logic               last_byte;
		logic signed [31:0] user_tag;
		logic [LEN_W-1:0]   request_length;
	} in_item_t;

	typedef struct packed {
		logic [7:0]         out_byte;
		logic               out_last;
		logic signed [31:0] out_tag;
		logic [LEN_W-1:0]   out_count;
		status_t            status;
	} result_t;

	// classified command handed from front to back
	typedef struct packed {
		func_t              op;
		logic               zero_req;
		logic [7:0]         data_byte;
		logic               last_byte;
		logic signed [31:0] user_tag;
		logic [LEN_W-1:0]   req;
	} cmd_t;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		next_slot = (s == SLOT_W'(RECORD_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

endpackage

/* sv/record_fifo_partial_read.sv */
// Record FIFO with partial read.
// Input channel: an item on item is taken when push is high and full is low.
// func selects append byte, get, delete or peek. Appends build the tail
// record one byte per beat; last_byte closes it and stores user_tag.
// Result channel: the oldest result sits on result while empty is low and
// leaves when pop is high. Append, delete and error items give one result;
// get and peek give one result per byte read, out_last on the final one.
// Items pass a 2-entry command queue, then the back end runs them one at a
// time. Get/peek items are classified, then each byte is read through the
// registered read port of the byte memory, and the final byte is handed
// over once the back end has left its stream state.
// A 4-entry result queue absorbs stalls: when pop stays low the back end
// stops once the queue is full, then the command queue fills and full rises.
// Reset clears all pointers, counters and queues; byte and record stores
// hold no reset value and are only read for closed records.
module record_fifo_partial_read (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  rfpr_pkg::in_item_t item,
	output logic              empty,
	input  logic              pop,
	output rfpr_pkg::result_t result
);
	import rfpr_pkg::*;

	logic                  cmd_valid;
	cmd_t                  cmd;
	logic                  cmd_pop;
	logic [RESQ_CNT_W-1:0] res_cnt;
	logic                  res_push;
	result_t               res_data;

	rfpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	rfpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_cnt   (res_cnt),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	rfpr_res_queue u_res_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_data (res_data),
		.res_cnt  (res_cnt),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

/* sv/rfpr_front.sv */
module rfpr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  rfpr_pkg::in_item_t item,
	output logic              cmd_valid,
	output rfpr_pkg::cmd_t    cmd,
	input  logic              cmd_pop
);
	import rfpr_pkg::*;

	cmd_t                  queue_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	cmd_t                  cls;
	logic                  wr_en;
	logic                  rd_en;

	always_comb begin
		cls.op        = item.func;
		cls.zero_req  = (item.request_length == '0);
		cls.data_byte = item.data_byte;
		cls.last_byte = item.last_byte;
		cls.user_tag  = item.user_tag;
		cls.req       = item.request_length;
	end

	assign full      = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* sv/rfpr_res_queue.sv */
module rfpr_res_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             res_push,
	input  rfpr_pkg::result_t                res_data,
	output logic [rfpr_pkg::RESQ_CNT_W-1:0]  res_cnt,
	output logic                             empty,
	input  logic                             pop,
	output rfpr_pkg::result_t                result
);
	import rfpr_pkg::*;

	result_t               queue_q [RESQ_DEPTH];
	logic [RESQ_PTR_W-1:0] wr_ptr_q;
	logic [RESQ_PTR_W-1:0] rd_ptr_q;
	logic [RESQ_CNT_W-1:0] cnt_q;
	logic                  rd_en;

	assign empty   = (cnt_q == '0);
	assign result  = queue_q[rd_ptr_q];
	assign res_cnt = cnt_q;
	assign rd_en   = pop && !empty;

	always_ff @(posedge clk) begin
		if (res_push) begin
			queue_q[wr_ptr_q] <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= (wr_ptr_q == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (res_push && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !res_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// back end reserves space before every beat it sends
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (cnt_q != RESQ_CNT_W'(RESQ_DEPTH)))
		else $error("result queue overflow");

endmodule

/* sv/rfpr_back.sv */
module rfpr_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	input  rfpr_pkg::cmd_t                  cmd,
	output logic                            cmd_pop,
	input  logic [rfpr_pkg::RESQ_CNT_W-1:0] res_cnt,
	output logic                            res_push,
	output rfpr_pkg::result_t               res_data
);
	import rfpr_pkg::*;

	logic [7:0]         mem [STORE_BYTES];
	logic [LEN_W-1:0]   len_mem_q [RECORD_SLOTS];
	logic signed [31:0] tag_mem_q [RECORD_SLOTS];

	back_state_t        state_q, state_d;
	logic [SLOT_W-1:0]  head_q, head_d;
	logic [SLOT_W-1:0]  tail_q, tail_d;
	logic [USED_W-1:0]  used_q, used_d;
	logic [OFF_W-1:0]   head_off_q, head_off_d;
	logic [LEN_W-1:0]   wr_off_q, wr_off_d;
	logic               err_q, err_d;
	logic [OFF_W-1:0]   rd_off_q, rd_off_d;
	logic [LEN_W-1:0]   cnt_q, cnt_d;
	logic [LEN_W-1:0]   take_q, take_d;
	logic signed [31:0] tag_q, tag_d;
	logic               is_get_q, is_get_d;
	logic               pop_end_q, pop_end_d;

	logic               rd_valid_s1;
	logic               rd_last_s1;
	logic [7:0]         rd_data_s1;

	logic               dir_push;
	result_t            dir_res;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [ADDR_W-1:0]  mem_raddr;
	logic               len_we;
	logic               rd_issue;
	logic               full_rec;
	logic [LEN_W-1:0]   head_len;
	logic [LEN_W-1:0]   rem;
	logic [LEN_W-1:0]   take;
	logic               req_lt_rem;
	logic [RESQ_CNT_W:0] pending;

	assign full_rec   = (used_q == USED_W'(RECORD_SLOTS));
	assign head_len   = len_mem_q[head_q];
	assign rem        = head_len - LEN_W'(head_off_q);
	assign req_lt_rem = (cmd.req < rem);
	assign take       = req_lt_rem ? cmd.req : rem;
	assign pending    = (RESQ_CNT_W + 1)'(res_cnt) + (RESQ_CNT_W + 1)'(rd_valid_s1);
	assign mem_waddr  = ADDR_W'(tail_q) * ADDR_W'(MAX_RECORD_BYTES) + ADDR_W'(wr_off_q);
	assign mem_raddr  = ADDR_W'(head_q) * ADDR_W'(MAX_RECORD_BYTES) + ADDR_W'(rd_off_q);

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		used_d     = used_q;
		head_off_d = head_off_q;
		wr_off_d   = wr_off_q;
		err_d      = err_q;
		rd_off_d   = rd_off_q;
		cnt_d      = cnt_q;
		take_d     = take_q;
		tag_d      = tag_q;
		is_get_d   = is_get_q;
		pop_end_d  = pop_end_q;
		cmd_pop    = 1'b0;
		dir_push   = 1'b0;
		dir_res    = '0;
		mem_we     = 1'b0;
		len_we     = 1'b0;
		rd_issue   = 1'b0;

		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && !rd_valid_s1 && (res_cnt != RESQ_CNT_W'(RESQ_DEPTH))) begin
					cmd_pop          = 1'b1;
					dir_push         = 1'b1;
					dir_res.out_last = 1'b1;
					if (cmd.op == FN_APPEND) begin
						if (err_q || full_rec || (wr_off_q == LEN_W'(MAX_RECORD_BYTES))) begin
							// drop the byte and the rest of the open record
							dir_res.status = full_rec ? ST_FULL : ST_TOO_LONG;
							wr_off_d       = '0;
							err_d          = !cmd.last_byte;
						end else begin
							mem_we            = 1'b1;
							wr_off_d          = wr_off_q + 1'b1;
							dir_res.out_count = wr_off_q + 1'b1;
							if (cmd.last_byte) begin
								len_we   = 1'b1;
								wr_off_d = '0;
								tail_d   = next_slot(tail_q);
								used_d   = used_q + 1'b1;
							end
						end
					end else if (cmd.zero_req || (used_q == '0)) begin
						dir_res.status = ST_EMPTY;
					end else if (cmd.op == FN_DELETE) begin
						dir_res.out_tag   = tag_mem_q[head_q];
						dir_res.out_count = take;
						if (req_lt_rem) begin
							head_off_d = head_off_q + OFF_W'(cmd.req);
						end else begin
							head_d     = next_slot(head_q);
							used_d     = used_q - 1'b1;
							head_off_d = '0;
						end
					end else begin
						// get or peek: stream the bytes
						dir_push  = 1'b0;
						state_d   = BK_STREAM;
						rd_off_d  = head_off_q;
						cnt_d     = take;
						take_d    = take;
						tag_d     = tag_mem_q[head_q];
						is_get_d  = (cmd.op == FN_GET);
						pop_end_d = !req_lt_rem;
					end
				end
			end
			BK_STREAM: begin
				if (pending < (RESQ_CNT_W + 1)'(RESQ_DEPTH)) begin
					rd_issue = 1'b1;
					rd_off_d = rd_off_q + 1'b1;
					cnt_d    = cnt_q - 1'b1;
					if (cnt_q == LEN_W'(1)) begin
						state_d = BK_IDLE;
						if (is_get_q) begin
							if (pop_end_q) begin
								head_d     = next_slot(head_q);
								used_d     = used_q - 1'b1;
								head_off_d = '0;
							end else begin
								head_off_d = head_off_q + OFF_W'(take_q);
							end
						end
					end
				end
			end
		endcase
	end

	always_comb begin
		res_push = dir_push || rd_valid_s1;
		if (rd_valid_s1) begin
			res_data.out_byte  = rd_data_s1;
			res_data.out_last  = rd_last_s1;
			res_data.out_tag   = tag_q;
			res_data.out_count = take_q;
			res_data.status    = ST_OK;
		end else begin
			res_data = dir_res;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= cmd.data_byte;
		end
		if (rd_issue) begin
			rd_data_s1 <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem_q[tail_q] <= wr_off_q + 1'b1;
			tag_mem_q[tail_q] <= cmd.user_tag;
		end
		take_q <= take_d;
		tag_q  <= tag_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			used_q      <= '0;
			head_off_q  <= '0;
			wr_off_q    <= '0;
			err_q       <= 1'b0;
			rd_off_q    <= '0;
			cnt_q       <= '0;
			is_get_q    <= 1'b0;
			pop_end_q   <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			used_q      <= used_d;
			head_off_q  <= head_off_d;
			wr_off_q    <= wr_off_d;
			err_q       <= err_d;
			rd_off_q    <= rd_off_d;
			cnt_q       <= cnt_d;
			is_get_q    <= is_get_d;
			pop_end_q   <= pop_end_d;
			rd_valid_s1 <= rd_issue;
			rd_last_s1  <= rd_issue && (cnt_q == LEN_W'(1));
		end
	end

	a_no_push_clash: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> !dir_push)
		else $error("direct result collides with streamed beat");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(RECORD_SLOTS))
		else $error("record count beyond slot count");

	a_stream_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_STREAM) |-> (cnt_q != '0))
		else $error("streaming with no bytes left");

	a_last_ends_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_issue && (cnt_q == LEN_W'(1))) |=> (state_q == BK_IDLE))
		else $error("stream did not end after final beat");

endmodule

/* test/tb_record_fifo_partial_read.sv */
`timescale 1ns / 1ps

module tb_record_fifo_partial_read;
	import rfpr_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 70;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam int DRAIN_CYCLES = 16;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     push = 1'b0;
	logic     pop = 1'b0;
	logic     full;
	logic     empty;
	in_item_t item = '0;
	result_t  result;

	record_fifo_partial_read uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the record store
	logic [7:0]  shadow_bytes [STORE_BYTES];
	int          shadow_len [RECORD_SLOTS];
	logic [31:0] shadow_tag [RECORD_SLOTS];
	int          shadow_head = 0;
	int          shadow_tail = 0;
	int          shadow_used = 0;
	int          shadow_hoff = 0;
	int          shadow_woff = 0;
	bit          shadow_drop = 1'b0;

	result_t expected_beats [$];
	int      mismatches = 0;
	int      items_sent = 0;
	int      beats_seen = 0;
	int      cycle_count = 0;
	bit      sender_calm = 1'b0;
	bit      receiver_calm = 1'b0;
	bit      hold_req = 1'b0;

	typedef struct {
		in_item_t stim;
		bit       typed;
		result_t  want;
	} plan_row_t;

	plan_row_t plan [$];
	func_t     read_funcs [3] = '{FN_GET, FN_DELETE, FN_PEEK};

	function automatic in_item_t mk(func_t f, logic [7:0] d, logic l, logic [31:0] tg,
			int req);
		in_item_t it;
		it.func           = f;
		it.data_byte      = d;
		it.last_byte      = l;
		it.user_tag       = tg;
		it.request_length = LEN_W'(req);
		return it;
	endfunction

	function automatic result_t beat(logic [7:0] b, logic l, logic [31:0] tg, int cnt,
			status_t st);
		result_t r;
		r.out_byte  = b;
		r.out_last  = l;
		r.out_tag   = tg;
		r.out_count = LEN_W'(cnt);
		r.status    = st;
		return r;
	endfunction

	function automatic int head_remaining();
		return (shadow_used > 0) ? shadow_len[shadow_head] - shadow_hoff : 0;
	endfunction

	// works out the beats one accepted item causes and advances the shadow state
	task automatic predict_record_op(in_item_t it);
		int          req;
		int          rem;
		int          k;
		logic [31:0] tg;
		bit          full_now;
		req = it.request_length;
		if (it.func == FN_APPEND) begin
			full_now = (shadow_used >= RECORD_SLOTS);
			if (shadow_drop || full_now || shadow_woff >= MAX_RECORD_BYTES) begin
				expected_beats.push_back(beat(8'h00, 1'b1, '0, 0,
					full_now ? ST_FULL : ST_TOO_LONG));
				shadow_woff = 0;
				shadow_drop = !it.last_byte;
			end else begin
				shadow_bytes[shadow_tail * MAX_RECORD_BYTES + shadow_woff] = it.data_byte;
				shadow_woff++;
				expected_beats.push_back(beat(8'h00, 1'b1, '0, shadow_woff, ST_OK));
				if (it.last_byte) begin
					shadow_len[shadow_tail] = shadow_woff;
					shadow_tag[shadow_tail] = it.user_tag;
					shadow_tail = (shadow_tail + 1) % RECORD_SLOTS;
					shadow_used++;
					shadow_woff = 0;
				end
			end
		end else if (req == 0 || shadow_used == 0) begin
			expected_beats.push_back(beat(8'h00, 1'b1, '0, 0, ST_EMPTY));
		end else begin
			rem = head_remaining();
			tg  = shadow_tag[shadow_head];
			k   = (req < rem) ? req : rem;
			if (it.func == FN_DELETE) begin
				expected_beats.push_back(beat(8'h00, 1'b1, tg, k, ST_OK));
			end else begin
				for (int i = 0; i < k; i++)
					expected_beats.push_back(beat(
						shadow_bytes[shadow_head * MAX_RECORD_BYTES + shadow_hoff + i],
						i == k - 1, tg, k, ST_OK));
			end
			if (it.func != FN_PEEK) begin
				if (req < rem) begin
					shadow_hoff += req;
				end else begin
					shadow_head = (shadow_head + 1) % RECORD_SLOTS;
					shadow_used--;
					shadow_hoff = 0;
				end
			end
		end
	endtask

	// returns at the edge where the item is taken, push still high
	task automatic send(in_item_t it);
		int gap;
		if (items_sent % 32 == 0)
			sender_calm = ($urandom_range(0, 3) == 0);
		gap = sender_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_record_op(it);
		items_sent++;
	endtask

	task automatic send_record(int n);
		for (int i = 0; i < n; i++)
			send(mk(FN_APPEND, 8'($urandom), i == n - 1, $urandom,
				$urandom_range(0, 64)));
	endtask

	function automatic int pick_request();
		int r;
		int rem;
		r   = $urandom_range(0, 9);
		rem = head_remaining();
		if (r == 0)
			return 0;
		if (r == 1)
			return 64;
		if (r < 4 || rem == 0)
			return $urandom_range(0, 64);
		return $urandom_range(1, (rem + 1 > 64) ? 64 : rem + 1);
	endfunction

	task automatic send_read();
		send(mk(read_funcs[$urandom_range(0, 2)], 8'($urandom), 1'($urandom_range(0, 1)),
			$urandom, pick_request()));
	endtask

	function automatic int pick_record_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 8);
		if (r < 92)
			return $urandom_range(9, 63);
		if (r < 96)
			return MAX_RECORD_BYTES;
		return $urandom_range(MAX_RECORD_BYTES + 1, MAX_RECORD_BYTES + 4);
	endfunction

	task automatic check_beat(result_t got);
		result_t want;
		if (expected_beats.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected beat: byte %h last %b tag %h count %0d status %0d",
					got.out_byte, got.out_last, got.out_tag, got.out_count, got.status);
		end else begin
			want = expected_beats.pop_front();
			if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
					got.out_tag !== want.out_tag || got.out_count !== want.out_count ||
					got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("beat %0d: expected byte %h last %b tag %h count %0d status %0d, ",
						beats_seen, want.out_byte, want.out_last, want.out_tag,
						want.out_count, want.status,
						"got byte %h last %b tag %h count %0d status %0d",
						got.out_byte, got.out_last, got.out_tag, got.out_count,
						got.status);
			end
		end
		beats_seen++;
	endtask

	// result side
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			if (beats_seen % 32 == 0)
				receiver_calm = ($urandom_range(0, 3) == 0);
			gap = receiver_calm ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			check_beat(result);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int r;
		int drained;
		plan.push_back('{mk(FN_GET, 8'h00, 1'b0, 32'h0, 5), 1'b1,
			beat(8'h00, 1'b1, 32'h0, 0, ST_EMPTY)});
		plan.push_back('{mk(FN_PEEK, 8'hFF, 1'b1, 32'hFFFFFFFF, 64), 1'b1,
			beat(8'h00, 1'b1, 32'h0, 0, ST_EMPTY)});
		plan.push_back('{mk(FN_DELETE, 8'h00, 1'b0, 32'h0, 1), 1'b1,
			beat(8'h00, 1'b1, 32'h0, 0, ST_EMPTY)});
		plan.push_back('{mk(FN_APPEND, 8'hFF, 1'b1, 32'h80000000, 0), 1'b1,
			beat(8'h00, 1'b1, 32'h0, 1, ST_OK)});
		plan.push_back('{mk(FN_APPEND, 8'h00, 1'b0, 32'h0, 64), 1'b1,
			beat(8'h00, 1'b1, 32'h0, 1, ST_OK)});
		plan.push_back('{mk(FN_APPEND, 8'hA5, 1'b0, 32'h0, 0), 1'b1,
			beat(8'h00, 1'b1, 32'h0, 2, ST_OK)});
		plan.push_back('{mk(FN_APPEND, 8'h5A, 1'b1, 32'h7FFFFFFF, 0), 1'b1,
			beat(8'h00, 1'b1, 32'h0, 3, ST_OK)});
		// zero-length request
		plan.push_back('{mk(FN_GET, 8'h00, 1'b0, 32'h0, 0), 1'b1,
			beat(8'h00, 1'b1, 32'h0, 0, ST_EMPTY)});
		plan.push_back('{mk(FN_PEEK, 8'h00, 1'b0, 32'h0, 64), 1'b0, '0});
		plan.push_back('{mk(FN_GET, 8'h00, 1'b0, 32'h0, 1), 1'b0, '0});
		plan.push_back('{mk(FN_PEEK, 8'h00, 1'b0, 32'h0, 2), 1'b0, '0});
		plan.push_back('{mk(FN_GET, 8'h00, 1'b0, 32'h0, 1), 1'b0, '0});
		plan.push_back('{mk(FN_DELETE, 8'h00, 1'b0, 32'h0, 1), 1'b0, '0});
		// oversized get is clipped and pops
		plan.push_back('{mk(FN_GET, 8'h00, 1'b0, 32'h0, 64), 1'b0, '0});
		plan.push_back('{mk(FN_DELETE, 8'h00, 1'b0, 32'h0, 64), 1'b1,
			beat(8'h00, 1'b1, 32'h0, 0, ST_EMPTY)});
		// open record stays invisible to reads
		plan.push_back('{mk(FN_APPEND, 8'h3C, 1'b0, 32'h0, 0), 1'b1,
			beat(8'h00, 1'b1, 32'h0, 1, ST_OK)});
		plan.push_back('{mk(FN_PEEK, 8'h00, 1'b0, 32'h0, 3), 1'b1,
			beat(8'h00, 1'b1, 32'h0, 0, ST_EMPTY)});
		plan.push_back('{mk(FN_APPEND, 8'hC3, 1'b1, 32'h12345678, 0), 1'b1,
			beat(8'h00, 1'b1, 32'h0, 2, ST_OK)});
		plan.push_back('{mk(FN_DELETE, 8'h00, 1'b0, 32'h0, 64), 1'b0, '0});
		plan.push_back('{mk(FN_GET, 8'h00, 1'b0, 32'h0, 1), 1'b1,
			beat(8'h00, 1'b1, 32'h0, 0, ST_EMPTY)});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			send(plan[i].stim);
			if (plan[i].typed) begin
				void'(expected_beats.pop_back());
				expected_beats.push_back(plan[i].want);
			end
		end

		// fill every slot while the result side holds off, then overflow
		hold_req = 1'b1;
		while (shadow_used < RECORD_SLOTS)
			send_record($urandom_range(1, 4));
		send_record(3);
		send_record(1);
		drained = 0;
		while (shadow_used > 0 && drained < 200) begin
			send_read();
			drained++;
		end

		// longest record, then records one and two bytes too long
		send_record(MAX_RECORD_BYTES);
		send(mk(FN_PEEK, 8'($urandom), 1'b0, $urandom, 64));
		send(mk(FN_GET, 8'($urandom), 1'b1, $urandom, 64));
		send_record(MAX_RECORD_BYTES + 1);
		send_record(MAX_RECORD_BYTES + 2);

		for (int n = 0; n < RANDOM_ITEMS; ) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				r = pick_record_len();
				send_record(r);
				n += r;
			end else if (r < 48) begin
				send(mk(FN_APPEND, 8'($urandom), 1'($urandom_range(0, 1)), $urandom,
					$urandom_range(0, 64)));
				n++;
			end else if (r < 52 && shadow_used < RECORD_SLOTS - 4) begin
				// burst of short records to push toward full again
				repeat (6) send_record($urandom_range(1, 3));
				n += 12;
			end else begin
				send_read();
				n++;
			end
		end

		push <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_beats.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
sv/rfpr_pkg.sv
sv/rfpr_front.sv
sv/rfpr_res_queue.sv
sv/rfpr_back.sv
sv/record_fifo_partial_read.sv
test/tb_record_fifo_partial_read.sv
